// ===== design/genotype_breeding_value_scorer_unit_defines.svh =====
// Assertion macros used by the scorer back end RTL.
`ifndef GENOTYPE_BREEDING_VALUE_SCORER_UNIT_DEFINES_SVH
`define GENOTYPE_BREEDING_VALUE_SCORER_UNIT_DEFINES_SVH

// Invariant that must hold at every clock edge outside reset.
`define GBVS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define GBVS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after its antecedent.
`define GBVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/gbvs_pkg.sv =====
// Shared types, constants and helper functions of the breeding value scorer.
package gbvs_pkg;

	localparam int MARKERS_DEF = 16384;
	localparam int ALLELES_DEF = 4;

	localparam int MARKER_W   = 14;
	localparam int ROW_W      = 2;
	localparam int EFFECT_W   = 32;
	localparam int SYM_W      = 8;
	localparam int COUNT_W    = 3;
	localparam int SUM_W      = 48;
	localparam int ADD_W      = 34;
	localparam int SYM_REGS   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int MIDQ_DEPTH = 4;
	localparam int OUT_DEPTH  = 8;

	localparam logic [COUNT_W-1:0] COUNT_RST = 3'd4;
	localparam logic [SYM_W-1:0]   SYM0_RST  = 8'd65;
	localparam logic [SYM_W-1:0]   SYM1_RST  = 8'd67;
	localparam logic [SYM_W-1:0]   SYM2_RST  = 8'd71;
	localparam logic [SYM_W-1:0]   SYM3_RST  = 8'd84;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SCORE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALLELE_COUNT = 3'd0,
		REG_SYMBOL_0     = 3'd1,
		REG_SYMBOL_1     = 3'd2,
		REG_SYMBOL_2     = 3'd3,
		REG_SYMBOL_3     = 3'd4
	} reg_idx_t;

	// Classified operation handed from the front end to the back end.
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_SCORE,
		OP_FLUSH
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [MARKER_W-1:0] addr;
		logic [ROW_W-1:0]    row;
		logic [EFFECT_W-1:0] effect;
		logic [SYM_W-1:0]    a1;
		logic [SYM_W-1:0]    a2;
		logic                last;
	} mid_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]                count;
		logic [SYM_REGS-1:0][SYM_W-1:0]    sym;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0] first;
		logic [SUM_W-1:0] second;
		logic [SUM_W-1:0] total;
		logic             sat;
	} result_t;

	typedef struct packed {
		logic [SUM_W-1:0] value;
		logic             clamp;
	} sat_t;

	// Clamps a 49-bit two's complement sum into the 48-bit signed range.
	function automatic sat_t sat48(input logic [SUM_W:0] s);
		sat_t r;
		r.clamp = s[SUM_W] ^ s[SUM_W-1];
		if (!r.clamp) begin
			r.value = s[SUM_W-1:0];
		end else if (s[SUM_W]) begin
			r.value = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			r.value = {1'b0, {(SUM_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== design/gbvs_front.sv =====
// Front end: accepts input beats, classifies them and queues the useful ones.
module gbvs_front import gbvs_pkg::*; #(
	parameter int MARKERS = MARKERS_DEF,
	parameter int ALLELES = ALLELES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       command,
	input  logic [MARKER_W-1:0]        marker_index,
	input  logic [ROW_W-1:0]           allele_row,
	input  logic [EFFECT_W-1:0]        effect_value,
	input  logic [SYM_W-1:0]           first_allele,
	input  logic [SYM_W-1:0]           second_allele,
	input  logic                       last_marker,
	output mid_item_t                  head,
	output logic                       head_valid,
	input  logic                       head_pop
);

	localparam int PW = $clog2(MIDQ_DEPTH);
	localparam int CW = $clog2(MIDQ_DEPTH + 1);

	mid_item_t         q_q [MIDQ_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	mid_item_t         item;
	logic              keep;
	logic              in_range;
	logic              row_ok;
	logic              wr;

	// A load outside the table or its rows and a score off the table without last are dropped here.
	always_comb begin
		in_range    = 32'(marker_index) < MARKERS;
		row_ok      = 32'(allele_row) < ALLELES;
		item.addr   = marker_index;
		item.row    = allele_row;
		item.effect = effect_value;
		item.a1     = first_allele;
		item.a2     = second_allele;
		item.last   = last_marker;
		if (command == CMD_LOAD) begin
			item.op = OP_LOAD;
			keep    = in_range && row_ok;
		end else if (in_range) begin
			item.op = OP_SCORE;
			keep    = 1'b1;
		end else begin
			item.op = OP_FLUSH;
			keep    = last_marker;
		end
	end

	assign full       = cnt_q == CW'(MIDQ_DEPTH);
	assign wr         = push && !full && keep;
	assign head_valid = cnt_q != '0;
	assign head       = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (head_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(head_pop);
		end
	end

endmodule

// ===== design/gbvs_back.sv =====
// Back end: banked effect memory, per-item effect sums and saturating accumulators.
`include "genotype_breeding_value_scorer_unit_defines.svh"

module gbvs_back import gbvs_pkg::*; #(
	parameter int MARKERS = MARKERS_DEF,
	parameter int ALLELES = ALLELES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  mid_item_t head,
	input  logic      head_valid,
	output logic      head_pop,
	input  logic      res_pop,
	output logic      res_wr,
	output result_t   res_data
);

	localparam int NBANK = (ALLELES > SYM_REGS) ? SYM_REGS : ALLELES;
	localparam int DEPTH = (MARKERS < (1 << MARKER_W)) ? MARKERS : (1 << MARKER_W);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = $clog2(OUT_DEPTH + 1);

	logic [RW-1:0]                     rsv_q;
	logic [AW-1:0]                     addr;
	logic [NBANK-1:0][EFFECT_W-1:0]    bank_rd;
	logic                              rsv_inc;

	logic                              valid_s1;
	logic                              score_s1;
	logic                              last_s1;
	logic [SYM_W-1:0]                  a1_s1;
	logic [SYM_W-1:0]                  a2_s1;
	logic [ADD_W-1:0]                  add1;
	logic [ADD_W-1:0]                  add2;

	logic                              valid_s2;
	logic                              last_s2;
	logic [ADD_W-1:0]                  add1_s2;
	logic [ADD_W-1:0]                  add2_s2;
	logic [SUM_W-1:0]                  acc1_q;
	logic [SUM_W-1:0]                  acc2_q;
	logic                              sat_seen_q;
	sat_t                              r1;
	sat_t                              r2;

	logic                              valid_s3;
	logic [SUM_W-1:0]                  first_s3;
	logic [SUM_W-1:0]                  second_s3;
	logic                              flag_s3;
	sat_t                              rt;

	// Each result in flight holds a slot of the result queue from the moment it leaves
	// the item queue, so the pipeline itself never has to stall.
	assign head_pop = head_valid && (rsv_q < RW'(OUT_DEPTH));
	assign rsv_inc  = head_pop && (head.op != OP_LOAD) && head.last;
	assign addr     = head.addr[AW-1:0];

	for (genvar j = 0; j < NBANK; j++) begin : g_bank
		logic [EFFECT_W-1:0] mem [DEPTH];
		logic [EFFECT_W-1:0] rd_s1;

		always_ff @(posedge clk) begin
			if (head_pop && head.op == OP_LOAD && head.row == ROW_W'(j)) begin
				mem[addr] <= head.effect;
			end
			if (head_pop && head.op == OP_SCORE) begin
				rd_s1 <= mem[addr];
			end
		end

		assign bank_rd[j] = rd_s1;
	end

	always_comb begin
		add1 = '0;
		add2 = '0;
		for (int j = 0; j < NBANK; j++) begin
			if (score_s1 && (COUNT_W'(j) < cfg.count) && a1_s1 == cfg.sym[j]) begin
				add1 = add1 + {{(ADD_W-EFFECT_W){bank_rd[j][EFFECT_W-1]}}, bank_rd[j]};
			end
			if (score_s1 && (COUNT_W'(j) < cfg.count) && a2_s1 == cfg.sym[j]) begin
				add2 = add2 + {{(ADD_W-EFFECT_W){bank_rd[j][EFFECT_W-1]}}, bank_rd[j]};
			end
		end
	end

	assign r1 = sat48({acc1_q[SUM_W-1], acc1_q} +
		{{(SUM_W+1-ADD_W){add1_s2[ADD_W-1]}}, add1_s2});
	assign r2 = sat48({acc2_q[SUM_W-1], acc2_q} +
		{{(SUM_W+1-ADD_W){add2_s2[ADD_W-1]}}, add2_s2});
	assign rt = sat48({first_s3[SUM_W-1], first_s3} + {second_s3[SUM_W-1], second_s3});

	assign res_wr         = valid_s3;
	assign res_data.first  = first_s3;
	assign res_data.second = second_s3;
	assign res_data.total  = rt.value;
	assign res_data.sat    = flag_s3 | rt.clamp;

	always_ff @(posedge clk) begin
		if (head_pop) begin
			score_s1 <= head.op == OP_SCORE;
			last_s1  <= head.last;
			a1_s1    <= head.a1;
			a2_s1    <= head.a2;
		end
		if (valid_s1) begin
			last_s2 <= last_s1;
			add1_s2 <= add1;
			add2_s2 <= add2;
		end
		if (valid_s2 && last_s2) begin
			first_s3  <= r1.value;
			second_s3 <= r2.value;
			flag_s3   <= sat_seen_q | r1.clamp | r2.clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_q      <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			acc1_q     <= '0;
			acc2_q     <= '0;
			sat_seen_q <= 1'b0;
		end else begin
			rsv_q    <= rsv_q + RW'(rsv_inc) - RW'(res_pop);
			valid_s1 <= head_pop && (head.op != OP_LOAD);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && last_s2;
			if (valid_s2) begin
				if (last_s2) begin
					acc1_q     <= '0;
					acc2_q     <= '0;
					sat_seen_q <= 1'b0;
				end else begin
					acc1_q     <= r1.value;
					acc2_q     <= r2.value;
					sat_seen_q <= sat_seen_q | r1.clamp | r2.clamp;
				end
			end
		end
	end

	`GBVS_ASSERT_ALWAYS(a_rsv_bound, rsv_q <= RW'(OUT_DEPTH), "result reservations overflow")
	`GBVS_ASSERT_SAME(a_wr_reserved, res_wr, rsv_q != '0, "result written without a reservation")
	`GBVS_ASSERT_NEXT(a_acc_cleared, valid_s2 && last_s2, acc1_q == '0 && acc2_q == '0 && !sat_seen_q, "accumulators not cleared after a result")
	`GBVS_ASSERT_NEXT(a_load_no_score, head_pop && head.op == OP_LOAD, !valid_s1, "load item entered the score pipeline")

endmodule

// ===== design/gbvs_result_fifo.sv =====
// Result queue that decouples the score pipeline from the consumer.
module gbvs_result_fifo import gbvs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  result_t wr_data,
	input  logic    pop,
	output logic    empty,
	output result_t head
);

	localparam int PW = $clog2(OUT_DEPTH);
	localparam int CW = $clog2(OUT_DEPTH + 1);

	result_t       q_q [OUT_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          rd;

	assign empty = cnt_q == '0;
	assign rd    = pop && !empty;
	assign head  = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

endmodule

// ===== design/genotype_breeding_value_scorer_unit.sv =====
// Top level of the genotype breeding value scorer: config registers and the three parts.
// A score beat marked last passes the item queue, s1, s2 and s3, then the result queue.
// Throughput: one input beat per cycle, loads and scores alike, while results are popped.
// Up to eight results can wait in the result queue; beyond that the item queue fills.
// Reset (arst_n low, asynchronous) empties both queues, clears the sums and the flag and
// restores the config registers; the effect memory keeps its contents and needs no sweep.
module genotype_breeding_value_scorer_unit import gbvs_pkg::*; #(
	parameter int MARKERS = MARKERS_DEF,
	parameter int ALLELES = ALLELES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         command,
	input  logic [MARKER_W-1:0]          marker_index,
	input  logic [ROW_W-1:0]             allele_row,
	input  logic signed [EFFECT_W-1:0]   effect_value,
	input  logic [SYM_W-1:0]             first_allele,
	input  logic [SYM_W-1:0]             second_allele,
	input  logic                         last_marker,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [SUM_W-1:0]      first_copy_score,
	output logic signed [SUM_W-1:0]      second_copy_score,
	output logic signed [SUM_W-1:0]      total_score,
	output logic                         saturated,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	logic [COUNT_W-1:0] count_q;
	logic [SYM_W-1:0]   sym_q [SYM_REGS];
	cfg_t               cfg;
	mid_item_t          head;
	logic               head_valid;
	logic               head_pop;
	logic               res_wr;
	result_t            res_data;
	result_t            res_head;

	// The config port never stalls; writes to indexes past the last register are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= COUNT_RST;
			sym_q[0] <= SYM0_RST;
			sym_q[1] <= SYM1_RST;
			sym_q[2] <= SYM2_RST;
			sym_q[3] <= SYM3_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ALLELE_COUNT: count_q  <= cfg_data[COUNT_W-1:0];
				REG_SYMBOL_0:     sym_q[0] <= cfg_data;
				REG_SYMBOL_1:     sym_q[1] <= cfg_data;
				REG_SYMBOL_2:     sym_q[2] <= cfg_data;
				REG_SYMBOL_3:     sym_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.count = count_q;
		for (int j = 0; j < SYM_REGS; j++) begin
			cfg.sym[j] = sym_q[j];
		end
	end

	// The front end drops beats that can have no effect and queues the rest.
	gbvs_front #(
		.MARKERS(MARKERS),
		.ALLELES(ALLELES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.marker_index (marker_index),
		.allele_row   (allele_row),
		.effect_value (effect_value),
		.first_allele (first_allele),
		.second_allele(second_allele),
		.last_marker  (last_marker),
		.head         (head),
		.head_valid   (head_valid),
		.head_pop     (head_pop)
	);

	// The back end writes or reads the effect banks, sums and accumulates.
	gbvs_back #(
		.MARKERS(MARKERS),
		.ALLELES(ALLELES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.res_pop    (pop && !empty),
		.res_wr     (res_wr),
		.res_data   (res_data)
	);

	gbvs_result_fifo u_result_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_wr),
		.wr_data (res_data),
		.pop     (pop),
		.empty   (empty),
		.head    (res_head)
	);

	assign first_copy_score  = res_head.first;
	assign second_copy_score = res_head.second;
	assign total_score       = res_head.total;
	assign saturated         = res_head.sat;

endmodule
